// ----- rtl/ssb_pkg.sv -----
// Shared types, constants and register codes of the sub-pixel shift block.
// Used by every module in rtl; depends on nothing.
package ssb_pkg;

    // Default sizes of the frame store and the fixed-point position
    localparam int MAX_WIDTH_DEF  = 512;
    localparam int MAX_HEIGHT_DEF = 512;
    localparam int FRAC_BITS_DEF  = 8;

    // Fixed field widths and the queue depth
    localparam int POS_W      = 9;
    localparam int CH_W       = 16;
    localparam int PIX_W      = 4 * CH_W;
    localparam int OFF_W      = 19;
    localparam int DIM_W      = 10;
    localparam int EDGE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 19;
    localparam int FIFO_DEPTH = 4;

    // Operation codes of an input word
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_RENDER = 1'b1;

    // Edge modes
    localparam logic [EDGE_W-1:0] EDGE_ZERO  = 2'd0;
    localparam logic [EDGE_W-1:0] EDGE_TILE  = 2'd1;
    localparam logic [EDGE_W-1:0] EDGE_CLAMP = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGER_MODE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_MODE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CHANNEL  = 3'd6;

    // Reset values of the sizing registers
    localparam logic [DIM_W-1:0] WIDTH_RST  = 10'd512;
    localparam logic [DIM_W-1:0] HEIGHT_RST = 10'd512;
    localparam logic [CH_W-1:0]  MAXCH_RST  = 16'd255;

    typedef struct packed {
        logic signed [OFF_W-1:0] offset_x;
        logic signed [OFF_W-1:0] offset_y;
        logic                    int_mode;
        logic [EDGE_W-1:0]       edge_mode;
        logic [DIM_W-1:0]        width;
        logic [DIM_W-1:0]        height;
        logic [CH_W-1:0]         max_channel;
    } t_cfg;

    // Control bits of one frame store access in the queue
    typedef struct packed {
        logic is_load;
        logic zero;
        logic first;
        logic last;
        logic int_mode;
    } t_ctrl;

endpackage

// ----- rtl/subpixel_shift_bilinear.sv -----
// Top level of the sub-pixel shift block: configuration registers, front
// end, access queue and back end. Depends on ssb_pkg, ssb_front, ssb_fifo, ssb_back.
//
// Load words write one pixel into a MAX_WIDTH x MAX_HEIGHT frame store with
// a single access; a load outside the store is dropped. Render words give one
// pixel, the four neighbors of (pos + offset) blended with FRAC_BITS-bit
// weights, truncated and clamped to max_channel, or in integer mode the one
// rounded pixel returned as stored. Every frame store access uses the
// store's single port, so a blended render makes four accesses and an
// integer mode render one; in tile mode each render first runs a bit-serial
// remainder, one step per coordinate bit. The store has no reset and must
// be loaded before it is read; configuration writes are always taken and
// are meant for an idle block.
module subpixel_shift_bilinear #(
    parameter int MAX_WIDTH  = ssb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ssb_pkg::MAX_HEIGHT_DEF,
    parameter int FRAC_BITS  = ssb_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_operation,
    input  logic [ssb_pkg::POS_W-1:0]         i_pos_x,
    input  logic [ssb_pkg::POS_W-1:0]         i_pos_y,
    input  logic [ssb_pkg::CH_W-1:0]          i_in_alpha,
    input  logic [ssb_pkg::CH_W-1:0]          i_in_red,
    input  logic [ssb_pkg::CH_W-1:0]          i_in_green,
    input  logic [ssb_pkg::CH_W-1:0]          i_in_blue,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [ssb_pkg::CH_W-1:0]          o_out_alpha,
    output logic [ssb_pkg::CH_W-1:0]          o_out_red,
    output logic [ssb_pkg::CH_W-1:0]          o_out_green,
    output logic [ssb_pkg::CH_W-1:0]          o_out_blue,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ssb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ssb_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int WW = 2 * FRAC_BITS + 1;
    localparam int CTW = $bits(ssb_pkg::t_ctrl);
    localparam int QW = CTW + AW + ssb_pkg::PIX_W + WW;

    ssb_pkg::t_cfg             r_cfg;
    ssb_pkg::t_ctrl            f_ctrl, b_ctrl;
    logic [AW-1:0]             f_addr, b_addr;
    logic [ssb_pkg::PIX_W-1:0] f_data, b_data;
    logic [WW-1:0]             f_weight, b_weight;
    logic                      f_push, q_ready, q_valid, b_pop;
    logic [QW-1:0]             q_in, q_out;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.offset_x    <= '0;
            r_cfg.offset_y    <= '0;
            r_cfg.int_mode    <= 1'b0;
            r_cfg.edge_mode   <= ssb_pkg::EDGE_ZERO;
            r_cfg.width       <= ssb_pkg::WIDTH_RST;
            r_cfg.height      <= ssb_pkg::HEIGHT_RST;
            r_cfg.max_channel <= ssb_pkg::MAXCH_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                ssb_pkg::REG_OFFSET_X:     r_cfg.offset_x    <= $signed(i_cfg_data);
                ssb_pkg::REG_OFFSET_Y:     r_cfg.offset_y    <= $signed(i_cfg_data);
                ssb_pkg::REG_INTEGER_MODE: r_cfg.int_mode    <= i_cfg_data[0];
                ssb_pkg::REG_EDGE_MODE:    r_cfg.edge_mode   <= i_cfg_data[ssb_pkg::EDGE_W-1:0];
                ssb_pkg::REG_IMAGE_WIDTH:  r_cfg.width       <= i_cfg_data[ssb_pkg::DIM_W-1:0];
                ssb_pkg::REG_IMAGE_HEIGHT: r_cfg.height      <= i_cfg_data[ssb_pkg::DIM_W-1:0];
                ssb_pkg::REG_MAX_CHANNEL:  r_cfg.max_channel <= i_cfg_data[ssb_pkg::CH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    ssb_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_operation (i_operation),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_pixel     ({i_in_alpha, i_in_red, i_in_green, i_in_blue}),
        .i_cfg       (r_cfg),
        .o_push      (f_push),
        .i_q_ready   (q_ready),
        .o_ctrl      (f_ctrl),
        .o_addr      (f_addr),
        .o_data      (f_data),
        .o_weight    (f_weight)
    );

    // Pack and unpack the queue word
    assign q_in = {f_ctrl, f_addr, f_data, f_weight};
    assign {b_ctrl, b_addr, b_data, b_weight} = q_out;

    ssb_fifo #(
        .W     (QW),
        .DEPTH (ssb_pkg::FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_push),
        .o_ready (q_ready),
        .i_data  (q_in),
        .o_valid (q_valid),
        .i_ready (b_pop),
        .o_data  (q_out)
    );

    ssb_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .o_pop         (b_pop),
        .i_ctrl        (b_ctrl),
        .i_addr        (b_addr),
        .i_data        (b_data),
        .i_weight      (b_weight),
        .i_max_channel (r_cfg.max_channel),
        .o_valid       (o_out_valid),
        .i_ready       (i_out_ready),
        .o_alpha       (o_out_alpha),
        .o_red         (o_out_red),
        .o_green       (o_out_green),
        .o_blue        (o_out_blue)
    );

endmodule

// ----- rtl/ssb_fifo.sv -----
// Short queue between the address front end and the blend back end.
// Depends on ssb_pkg for its default depth.
module ssb_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = ssb_pkg::FIFO_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [W-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNW = $clog2(DEPTH + 1);

    logic [W-1:0]   r_mem [DEPTH];
    logic [PW-1:0]  r_wr, r_rd;
    logic [CNW-1:0] r_cnt;
    logic           push, pop;

    assign o_ready = (r_cnt != CNW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    // Store a word at the write pointer
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Advance pointers and track the fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/ssb_front.sv -----
// Front end: takes input words, computes source positions, edge handling,
// store addresses and blend weights, and issues one store access per cycle while the queue has room.
// Depends on ssb_pkg.
module ssb_front #(
    parameter int MAX_WIDTH  = ssb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ssb_pkg::MAX_HEIGHT_DEF,
    parameter int FRAC_BITS  = ssb_pkg::FRAC_BITS_DEF,
    localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT),
    localparam int WW = 2 * FRAC_BITS + 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_operation,
    input  logic [ssb_pkg::POS_W-1:0]     i_pos_x,
    input  logic [ssb_pkg::POS_W-1:0]     i_pos_y,
    input  logic [ssb_pkg::PIX_W-1:0]     i_pixel,
    input  ssb_pkg::t_cfg                 i_cfg,
    output logic                          o_push,
    input  logic                          i_q_ready,
    output ssb_pkg::t_ctrl                o_ctrl,
    output logic [AW-1:0]                 o_addr,
    output logic [ssb_pkg::PIX_W-1:0]     o_data,
    output logic [WW-1:0]                 o_weight
);

    localparam int POS_W = ssb_pkg::POS_W;
    localparam int OFF_W = ssb_pkg::OFF_W;
    localparam int SXW = ((POS_W + FRAC_BITS > OFF_W) ? POS_W + FRAC_BITS : OFF_W) + 2;
    localparam int DWW = $clog2(MAX_WIDTH + 1);
    localparam int DWH = $clog2(MAX_HEIGHT + 1);
    localparam int DW0 = (DWW > DWH) ? DWW : DWH;
    localparam int DW  = (DW0 > ssb_pkg::DIM_W) ? DW0 : ssb_pkg::DIM_W;
    localparam int CW  = ((SXW - FRAC_BITS + 1) > (DW + 1)) ? SXW - FRAC_BITS + 1 : DW + 1;
    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int KW  = $clog2(CW + 1);

    localparam logic signed [SXW-1:0] HALF = SXW'(1 << (FRAC_BITS - 1));
    localparam logic signed [SXW-1:0] ONEM = SXW'((1 << FRAC_BITS) - 1);
    localparam logic [FRAC_BITS:0]    ONE_U = (FRAC_BITS + 1)'(1 << FRAC_BITS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    // Input holding stage
    logic                      r_a_valid;
    logic                      r_a_op;
    logic [POS_W-1:0]          r_a_px, r_a_py;
    logic [ssb_pkg::PIX_W-1:0] r_a_pix;

    // Issue stage
    logic [1:0]                r_b_state;
    logic                      r_b_op;
    logic [ssb_pkg::PIX_W-1:0] r_b_pix;
    logic signed [CW-1:0]      r_x, r_y;
    logic [FRAC_BITS-1:0]      r_fx, r_fy;
    logic [1:0]                r_k;

    // Remainder units for tile mode
    logic [CW-1:0]             r_xmag, r_ymag;
    logic [DW-1:0]             r_xrem, r_yrem;
    logic                      r_xneg, r_yneg;
    logic [KW-1:0]             r_cnt;

    logic [DW-1:0]             w_ext, h_ext, w_sat, h_sat;
    logic signed [SXW-1:0]     sx, sy, tx, ty, tzx, tzy;
    logic signed [CW-1:0]      x0, y0;
    logic [FRAC_BITS-1:0]      fx0, fy0;
    logic                      load_ok, take, single, last_k, emit_last;
    logic [DW:0]               xtr, ytr, xnr, ynr;
    logic [DW-1:0]             xfin, yfin;
    logic signed [CW-1:0]      ws, hs, cx, cy, mx, my;
    logic                      outside;
    logic [FRAC_BITS:0]        gx, gy, wx, wy;
    logic [2*FRAC_BITS+1:0]    wprod;

    // Saturate the image size to the store, a zero size counting as one
    always_comb begin
        w_ext = DW'(i_cfg.width);
        h_ext = DW'(i_cfg.height);
        w_sat = (w_ext == '0) ? DW'(1) : ((w_ext > DW'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : w_ext);
        h_sat = (h_ext == '0) ? DW'(1) : ((h_ext > DW'(MAX_HEIGHT)) ? DW'(MAX_HEIGHT) : h_ext);
        ws    = CW'(w_sat);
        hs    = CW'(h_sat);
    end

    // Form the source position and its integer and fraction parts
    always_comb begin
        sx  = $signed({{(SXW - POS_W - FRAC_BITS){1'b0}}, r_a_px, {FRAC_BITS{1'b0}}})
            + $signed({{(SXW - OFF_W){i_cfg.offset_x[OFF_W-1]}}, i_cfg.offset_x});
        sy  = $signed({{(SXW - POS_W - FRAC_BITS){1'b0}}, r_a_py, {FRAC_BITS{1'b0}}})
            + $signed({{(SXW - OFF_W){i_cfg.offset_y[OFF_W-1]}}, i_cfg.offset_y});
        tx  = sx + HALF;
        ty  = sy + HALF;
        tzx = tx + (tx[SXW-1] ? ONEM : '0);
        tzy = ty + (ty[SXW-1] ? ONEM : '0);
        if (i_cfg.int_mode) begin
            x0  = CW'($signed(tzx[SXW-1:FRAC_BITS]));
            y0  = CW'($signed(tzy[SXW-1:FRAC_BITS]));
            fx0 = '0;
            fy0 = '0;
        end else begin
            x0  = CW'($signed(sx[SXW-1:FRAC_BITS]));
            y0  = CW'($signed(sy[SXW-1:FRAC_BITS]));
            fx0 = sx[FRAC_BITS-1:0];
            fy0 = sy[FRAC_BITS-1:0];
        end
        load_ok = (32'(r_a_px) < MAX_WIDTH) && (32'(r_a_py) < MAX_HEIGHT);
    end

    // One remainder step per cycle, with the positive fix-up on the last
    always_comb begin
        xtr  = {r_xrem, r_xmag[CW-1]};
        ytr  = {r_yrem, r_ymag[CW-1]};
        xnr  = (xtr >= {1'b0, w_sat}) ? xtr - {1'b0, w_sat} : xtr;
        ynr  = (ytr >= {1'b0, h_sat}) ? ytr - {1'b0, h_sat} : ytr;
        xfin = (r_xneg && xnr[DW-1:0] != '0) ? w_sat - xnr[DW-1:0] : xnr[DW-1:0];
        yfin = (r_yneg && ynr[DW-1:0] != '0) ? h_sat - ynr[DW-1:0] : ynr[DW-1:0];
    end

    // Neighbor coordinate, edge handling, address and weight
    always_comb begin
        single    = (r_b_op == ssb_pkg::OP_LOAD) || i_cfg.int_mode;
        last_k    = single || (r_k == 2'd3);
        emit_last = (r_b_state == S_EMIT) && i_q_ready && last_k;
        cx        = r_x + CW'(r_k[0]);
        cy        = r_y + CW'(r_k[1]);
        outside   = 1'b0;
        mx        = cx;
        my        = cy;
        if (r_b_op == ssb_pkg::OP_RENDER) begin
            unique case (i_cfg.edge_mode)
                ssb_pkg::EDGE_TILE: begin
                    mx = (cx == ws) ? '0 : cx;
                    my = (cy == hs) ? '0 : cy;
                end
                ssb_pkg::EDGE_CLAMP: begin
                    mx = (cx < 0) ? '0 : ((cx > ws - CW'(1)) ? ws - CW'(1) : cx);
                    my = (cy < 0) ? '0 : ((cy > hs - CW'(1)) ? hs - CW'(1) : cy);
                end
                default: begin
                    outside = (cx < 0) || (cx >= ws) || (cy < 0) || (cy >= hs);
                end
            endcase
        end
        o_addr = AW'(my[YW-1:0]) * AW'(MAX_WIDTH) + AW'(mx[XW-1:0]);
        gx     = ONE_U - {1'b0, r_fx};
        gy     = ONE_U - {1'b0, r_fy};
        wx     = r_k[0] ? {1'b0, r_fx} : gx;
        wy     = r_k[1] ? {1'b0, r_fy} : gy;
        wprod  = wx * wy;
    end

    assign o_weight        = wprod[WW-1:0];
    assign o_data          = r_b_pix;
    assign o_push          = (r_b_state == S_EMIT);
    assign o_ctrl.is_load  = (r_b_op == ssb_pkg::OP_LOAD);
    assign o_ctrl.zero     = outside;
    assign o_ctrl.first    = (r_k == 2'd0);
    assign o_ctrl.last     = last_k;
    assign o_ctrl.int_mode = i_cfg.int_mode;

    assign take    = r_a_valid && ((r_b_state == S_IDLE) || emit_last);
    assign o_ready = !r_a_valid || take;

    // Hold the accepted word until the issue stage takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_a_valid <= 1'b1;
        end else if (take) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_a_op  <= i_operation;
            r_a_px  <= i_pos_x;
            r_a_py  <= i_pos_y;
            r_a_pix <= i_pixel;
        end
    end

    // Issue sequencer: take, reduce for tile mode, emit accesses
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_state <= S_IDLE;
            r_k       <= '0;
            r_cnt     <= '0;
        end else if (take) begin
            r_k   <= '0;
            r_cnt <= '0;
            if (r_a_op == ssb_pkg::OP_LOAD) begin
                r_b_state <= load_ok ? S_EMIT : S_IDLE;
            end else if (i_cfg.edge_mode == ssb_pkg::EDGE_TILE) begin
                r_b_state <= S_DIV;
            end else begin
                r_b_state <= S_EMIT;
            end
        end else begin
            unique case (r_b_state)
                S_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == KW'(CW - 1)) begin
                        r_b_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (i_q_ready) begin
                        if (last_k) begin
                            r_b_state <= S_IDLE;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                default: begin
                    r_b_state <= S_IDLE;
                end
            endcase
        end
    end

    // Issue payload and remainder datapath
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_b_op  <= r_a_op;
            r_b_pix <= r_a_pix;
            r_xrem  <= '0;
            r_yrem  <= '0;
            if (r_a_op == ssb_pkg::OP_LOAD) begin
                r_x  <= CW'(r_a_px);
                r_y  <= CW'(r_a_py);
                r_fx <= '0;
                r_fy <= '0;
            end else begin
                r_x    <= x0;
                r_y    <= y0;
                r_fx   <= fx0;
                r_fy   <= fy0;
                r_xneg <= x0[CW-1];
                r_yneg <= y0[CW-1];
                r_xmag <= x0[CW-1] ? CW'(-x0) : CW'(x0);
                r_ymag <= y0[CW-1] ? CW'(-y0) : CW'(y0);
            end
        end else if (r_b_state == S_DIV) begin
            r_xrem <= xnr[DW-1:0];
            r_yrem <= ynr[DW-1:0];
            r_xmag <= r_xmag << 1;
            r_ymag <= r_ymag << 1;
            if (r_cnt == KW'(CW - 1)) begin
                r_x <= CW'(xfin);
                r_y <= CW'(yfin);
            end
        end
    end

endmodule

// ----- rtl/ssb_back.sv -----
// Back end: frame store, weighted accumulation of neighbors, clamp and
// the output register. Depends on ssb_pkg.
module ssb_back #(
    parameter int MAX_WIDTH  = ssb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ssb_pkg::MAX_HEIGHT_DEF,
    parameter int FRAC_BITS  = ssb_pkg::FRAC_BITS_DEF,
    localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT),
    localparam int WW = 2 * FRAC_BITS + 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_valid,
    output logic                       o_pop,
    input  ssb_pkg::t_ctrl             i_ctrl,
    input  logic [AW-1:0]              i_addr,
    input  logic [ssb_pkg::PIX_W-1:0]  i_data,
    input  logic [WW-1:0]              i_weight,
    input  logic [ssb_pkg::CH_W-1:0]   i_max_channel,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [ssb_pkg::CH_W-1:0]   o_alpha,
    output logic [ssb_pkg::CH_W-1:0]   o_red,
    output logic [ssb_pkg::CH_W-1:0]   o_green,
    output logic [ssb_pkg::CH_W-1:0]   o_blue
);

    localparam int CH_W  = ssb_pkg::CH_W;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int PRW   = CH_W + WW;
    localparam int ACW   = PRW + 2;
    localparam int RW    = ACW - 2 * FRAC_BITS;

    logic [ssb_pkg::PIX_W-1:0] r_mem [DEPTH];
    logic [ssb_pkg::PIX_W-1:0] r_rd;
    logic                      en;

    logic                      r_s1_valid, r_s2_valid, r_out_valid;
    ssb_pkg::t_ctrl            r_s1_ctrl, r_s2_ctrl;
    logic [WW-1:0]             r_s1_w;
    logic [PRW-1:0]            r_prod [4];
    logic [CH_W-1:0]           r_pix  [4];
    logic [ACW-1:0]            r_acc  [4];
    logic [CH_W-1:0]           r_out  [4];

    // Move the whole pipe unless a finished word is stuck at the output
    assign en    = !r_out_valid || i_ready;
    assign o_pop = i_q_valid && en;

    // Single-port frame store: a load writes, a fetch reads
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            if (i_ctrl.is_load) begin
                r_mem[i_addr] <= i_data;
            end else begin
                r_rd <= r_mem[i_addr];
            end
        end
    end

    // Stage valids and the output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en) begin
                r_s1_valid <= o_pop && !i_ctrl.is_load;
                r_s2_valid <= r_s1_valid;
            end
            if (en && r_s2_valid && r_s2_ctrl.last) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_ctrl <= i_ctrl;
            r_s1_w    <= i_weight;
            r_s2_ctrl <= r_s1_ctrl;
        end
    end

    // One lane per channel: weight, accumulate, scale and clamp, or in integer mode pass the pixel through
    for (genvar c = 0; c < 4; c++) begin : g_lane
        logic [CH_W-1:0] ch;
        logic [ACW-1:0]  sumc;
        logic [RW-1:0]   res;
        logic [CH_W-1:0] clamped;

        always_comb begin
            ch      = r_rd[(3 - c) * CH_W +: CH_W];
            sumc    = r_s2_ctrl.first ? ACW'(r_prod[c]) : r_acc[c] + ACW'(r_prod[c]);
            res     = sumc[ACW-1:2*FRAC_BITS];
            clamped = (res > RW'(i_max_channel)) ? i_max_channel : res[CH_W-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_prod[c] <= r_s1_ctrl.zero ? '0 : ch * r_s1_w;
                r_pix[c]  <= r_s1_ctrl.zero ? '0 : ch;
                if (r_s2_valid) begin
                    r_acc[c] <= sumc;
                    if (r_s2_ctrl.last) begin
                        r_out[c] <= r_s2_ctrl.int_mode ? r_pix[c] : clamped;
                    end
                end
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_alpha = r_out[0];
    assign o_red   = r_out[1];
    assign o_green = r_out[2];
    assign o_blue  = r_out[3];

endmodule

// ----- rtl/ssb_checker.sv -----
// Port-level checks of the sub-pixel shift block, bound to the top level.
// Depends on ssb_pkg and subpixel_shift_bilinear.
module ssb_checker (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_ready,
    input logic                     i_operation,
    input logic                     o_out_valid,
    input logic                     i_out_ready,
    input logic [ssb_pkg::CH_W-1:0] o_out_alpha,
    input logic [ssb_pkg::CH_W-1:0] o_out_blue,
    input logic                     o_cfg_ready
);

    logic [4:0] r_pend, n_pend;
    logic       ren_acc, out_acc;

    assign ren_acc = i_in_valid && o_in_ready && (i_operation == ssb_pkg::OP_RENDER);
    assign out_acc = o_out_valid && i_out_ready;

    // Count renders taken but not yet delivered
    always_comb begin
        n_pend = r_pend + {4'd0, ren_acc} - {4'd0, out_acc};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= n_pend;
        end
    end

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_pend != '0))
        else $error("result word without an outstanding render");

    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend == '0 && !o_out_valid) |=> !o_out_valid || (r_pend != '0))
        else $error("result word after loads only");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("configuration port stalled");

    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result word right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            o_out_valid && $stable(o_out_alpha) && $stable(o_out_blue))
        else $error("stalled result word changed");

endmodule

bind subpixel_shift_bilinear ssb_checker u_ssb_checker (.*);

// ----- tb/tb_subpixel_shift_bilinear.sv -----
// Self-checking testbench of subpixel_shift_bilinear: loads and renders go in
// through a valid/ready driver, a monitor predicts every render and checks it.
// Depends on ssb_pkg and the subpixel_shift_bilinear RTL.
module tb_subpixel_shift_bilinear;
    import ssb_pkg::*;

    localparam int STORE_W   = 512;
    localparam int STORE_H   = 512;
    localparam int ONE       = 256;
    localparam int HALF      = 128;
    localparam int SETTLE    = 40;
    localparam int WDOG_MAX  = 4000;
    localparam int RENDERS   = 55;

    typedef struct {
        logic            op;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [CH_W-1:0] a;
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
    } t_word;

    logic i_clk, i_rst_n;
    logic i_in_valid, o_in_ready, i_operation;
    logic [POS_W-1:0] i_pos_x, i_pos_y;
    logic [CH_W-1:0] i_in_alpha, i_in_red, i_in_green, i_in_blue;
    logic o_out_valid, i_out_ready;
    logic [CH_W-1:0] o_out_alpha, o_out_red, o_out_green, o_out_blue;
    logic i_cfg_valid, o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    subpixel_shift_bilinear u_dut (.*);

    // Pixel store mirror, written-map used by the stimulus, pending words
    logic [PIX_W-1:0] frame_mem [STORE_W*STORE_H];
    bit               gen_written [STORE_W*STORE_H];
    t_word            word_q [$];
    logic [PIX_W-1:0] pixel_q [$];
    t_cfg             dut_cfg;
    t_cfg             gen_cfg;
    int               src_idle;
    int               snk_idle;
    int               err_cnt;
    int               stall_cnt;
    logic             in_fire;

    // Fetch one neighbor after applying the edge mode
    function automatic logic [PIX_W-1:0] fetch_px(t_cfg c, longint x, longint y,
                                                  bit probe, inout bit ok);
        longint w, h, addr;
        w = longint'(c.width);
        h = longint'(c.height);
        if (w < 1) w = 1;
        if (w > STORE_W) w = STORE_W;
        if (h < 1) h = 1;
        if (h > STORE_H) h = STORE_H;
        if (c.edge_mode == EDGE_TILE) begin
            x = ((x % w) + w) % w;
            y = ((y % h) + h) % h;
        end else if (c.edge_mode == EDGE_CLAMP) begin
            if (x < 0) x = 0;
            if (x > w - 1) x = w - 1;
            if (y < 0) y = 0;
            if (y > h - 1) y = h - 1;
        end else if (x < 0 || x >= w || y < 0 || y >= h) begin
            return '0;
        end
        addr = y * STORE_W + x;
        if (probe) begin
            if (!gen_written[addr]) ok = 0;
            return '0;
        end
        return frame_mem[addr];
    endfunction

    // Shifted output pixel; in probe mode only check that every read is loaded
    function automatic logic [PIX_W-1:0] shade_pixel(t_cfg c, logic [POS_W-1:0] px,
                                                     logic [POS_W-1:0] py, bit probe,
                                                     output bit ok);
        longint sx, sy, x1, y1, fx, fy, gx, gy, sum;
        logic [PIX_W-1:0] p1, p2, p3, p4, res;
        ok = 1;
        sx = longint'(px) * ONE + longint'($signed(c.offset_x));
        sy = longint'(py) * ONE + longint'($signed(c.offset_y));
        if (c.int_mode)
            return fetch_px(c, (sx + HALF) / ONE, (sy + HALF) / ONE, probe, ok);
        x1 = sx >>> 8;
        y1 = sy >>> 8;
        fx = sx - x1 * ONE;
        fy = sy - y1 * ONE;
        gx = ONE - fx;
        gy = ONE - fy;
        p1 = fetch_px(c, x1, y1, probe, ok);
        p2 = fetch_px(c, x1 + 1, y1, probe, ok);
        p3 = fetch_px(c, x1, y1 + 1, probe, ok);
        p4 = fetch_px(c, x1 + 1, y1 + 1, probe, ok);
        for (int k = 0; k < 4; k++) begin
            sum = longint'(p1[k*CH_W +: CH_W]) * gx * gy
                + longint'(p2[k*CH_W +: CH_W]) * fx * gy
                + longint'(p3[k*CH_W +: CH_W]) * gx * fy
                + longint'(p4[k*CH_W +: CH_W]) * fx * fy;
            sum = sum >> 16;
            if (sum > longint'(c.max_channel)) sum = longint'(c.max_channel);
            res[k*CH_W +: CH_W] = sum[CH_W-1:0];
        end
        return res;
    endfunction

    // Clock
    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // Driver: present the next queued word, hold it until accepted; randomize output ready
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= snk_idle);
        if (i_rst_n && (!i_in_valid || in_fire)) begin
            if (word_q.size() != 0 && $urandom_range(0, 99) >= src_idle) begin
                t_word w;
                w = word_q.pop_front();
                i_in_valid  <= 1'b1;
                i_operation <= w.op;
                i_pos_x     <= w.x;
                i_pos_y     <= w.y;
                i_in_alpha  <= w.a;
                i_in_red    <= w.r;
                i_in_green  <= w.g;
                i_in_blue   <= w.b;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Monitor: track config and loads, predict renders, check results
    always @(posedge i_clk) begin
        bit ok;
        logic [PIX_W-1:0] exp_px;
        in_fire <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_OFFSET_X:     dut_cfg.offset_x    = i_cfg_data;
                    REG_OFFSET_Y:     dut_cfg.offset_y    = i_cfg_data;
                    REG_INTEGER_MODE: dut_cfg.int_mode    = i_cfg_data[0];
                    REG_EDGE_MODE:    dut_cfg.edge_mode   = i_cfg_data[EDGE_W-1:0];
                    REG_IMAGE_WIDTH:  dut_cfg.width       = i_cfg_data[DIM_W-1:0];
                    REG_IMAGE_HEIGHT: dut_cfg.height      = i_cfg_data[DIM_W-1:0];
                    REG_MAX_CHANNEL:  dut_cfg.max_channel = i_cfg_data[CH_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                if (i_operation == OP_LOAD)
                    frame_mem[int'(i_pos_y) * STORE_W + int'(i_pos_x)] =
                        {i_in_alpha, i_in_red, i_in_green, i_in_blue};
                else
                    pixel_q.push_back(shade_pixel(dut_cfg, i_pos_x, i_pos_y, 0, ok));
            end
            if (o_out_valid && i_out_ready) begin
                if (pixel_q.size() == 0) begin
                    $error("unexpected output word");
                    err_cnt++;
                end else begin
                    exp_px = pixel_q.pop_front();
                    if (o_out_alpha !== exp_px[63:48]) begin
                        $error("out_alpha: expected %0d, got %0d", exp_px[63:48], o_out_alpha);
                        err_cnt++;
                    end
                    if (o_out_red !== exp_px[47:32]) begin
                        $error("out_red: expected %0d, got %0d", exp_px[47:32], o_out_red);
                        err_cnt++;
                    end
                    if (o_out_green !== exp_px[31:16]) begin
                        $error("out_green: expected %0d, got %0d", exp_px[31:16], o_out_green);
                        err_cnt++;
                    end
                    if (o_out_blue !== exp_px[15:0]) begin
                        $error("out_blue: expected %0d, got %0d", exp_px[15:0], o_out_blue);
                        err_cnt++;
                    end
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= WDOG_MAX) begin
            $display("** subpixel_shift_bilinear: FAILED **");
            $finish;
        end
    end

    function automatic logic [CH_W-1:0] rnd_ch();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 16'd32768;
            default: return CH_W'($urandom_range(0, 32767));
        endcase
    endfunction

    function automatic void push_load(int x, int y);
        t_word w;
        w.op = OP_LOAD;
        w.x = POS_W'(x);
        w.y = POS_W'(y);
        w.a = rnd_ch();
        w.r = rnd_ch();
        w.g = rnd_ch();
        w.b = rnd_ch();
        gen_written[y * STORE_W + x] = 1;
        word_q.push_back(w);
    endfunction

    // Queue a render only if every pixel it reads has been loaded
    function automatic bit push_render(int x, int y);
        t_word w;
        bit ok;
        void'(shade_pixel(gen_cfg, POS_W'(x), POS_W'(y), 1, ok));
        if (!ok) return 0;
        w = '{OP_RENDER, POS_W'(x), POS_W'(y), '0, '0, '0, '0};
        word_q.push_back(w);
        return 1;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Hold off until every queued word is taken and every result is back
    task automatic wait_idle();
        while (word_q.size() != 0 || i_in_valid || pixel_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // One configuration phase: set registers, fill the image, render around it
    task automatic run_phase(int w, int h, int ox, int oy, int im, int em, int mc,
                             int renders);
        int ew, eh, done, tries, tx, ty, px, py;
        wait_idle();
        gen_cfg.offset_x    = OFF_W'(ox);
        gen_cfg.offset_y    = OFF_W'(oy);
        gen_cfg.int_mode    = im[0];
        gen_cfg.edge_mode   = EDGE_W'(em);
        gen_cfg.width       = DIM_W'(w);
        gen_cfg.height      = DIM_W'(h);
        gen_cfg.max_channel = CH_W'(mc);
        write_reg(REG_OFFSET_X, gen_cfg.offset_x);
        write_reg(REG_OFFSET_Y, gen_cfg.offset_y);
        write_reg(REG_INTEGER_MODE, CFG_DATA_W'(gen_cfg.int_mode));
        write_reg(REG_EDGE_MODE, CFG_DATA_W'(gen_cfg.edge_mode));
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(gen_cfg.width));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(gen_cfg.height));
        write_reg(REG_MAX_CHANNEL, CFG_DATA_W'(gen_cfg.max_channel));
        ew = (w < 1) ? 1 : (w > STORE_W) ? STORE_W : w;
        eh = (h < 1) ? 1 : (h > STORE_H) ? STORE_H : h;
        // fill small images whole, large ones at the four corners
        for (int y = 0; y < eh; y++)
            for (int x = 0; x < ew; x++)
                if (ew * eh <= 64 || ((x < 4 || x >= ew - 4) && (y < 4 || y >= eh - 4)))
                    push_load(x, y);
        done = 0;
        tries = 0;
        while (done < renders && tries < renders * 40) begin
            tries++;
            if ($urandom_range(0, 99) < 12) begin
                push_load($urandom_range(0, STORE_W - 1), $urandom_range(0, STORE_H - 1));
                continue;
            end
            if ($urandom_range(0, 99) < 20) begin
                px = $urandom_range(0, STORE_W - 1);
                py = $urandom_range(0, STORE_H - 1);
            end else begin
                tx = (ew <= 8 || $urandom_range(0, 1)) ? $urandom_range(0, ew + 1) - 1
                                                       : ew - 5 + $urandom_range(0, 5);
                ty = (eh <= 8 || $urandom_range(0, 1)) ? $urandom_range(0, eh + 1) - 1
                                                       : eh - 5 + $urandom_range(0, 5);
                px = tx - (ox >>> 8);
                py = ty - (oy >>> 8);
                if (px < 0 || px >= STORE_W) px = $urandom_range(0, STORE_W - 1);
                if (py < 0 || py >= STORE_H) py = $urandom_range(0, STORE_H - 1);
            end
            done += push_render(px, py);
        end
    endtask

    // Stimulus
    initial begin
        i_rst_n = 0;
        i_in_valid = 0;
        i_operation = OP_LOAD;
        i_pos_x = '0;
        i_pos_y = '0;
        i_in_alpha = '0;
        i_in_red = '0;
        i_in_green = '0;
        i_in_blue = '0;
        i_out_ready = 0;
        i_cfg_valid = 0;
        i_cfg_index = REG_OFFSET_X;
        i_cfg_data = '0;
        in_fire = 0;
        err_cnt = 0;
        stall_cnt = 0;
        src_idle = 23;
        snk_idle = 77;
        dut_cfg = '{0, 0, 0, EDGE_ZERO, WIDTH_RST, HEIGHT_RST, MAXCH_RST};
        gen_cfg = dut_cfg;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed: corners at reset settings, extreme pixels
        push_load(0, 0);
        push_load(1, 0);
        push_load(0, 1);
        push_load(1, 1);
        push_load(511, 0);
        push_load(511, 1);
        push_load(0, 511);
        push_load(1, 511);
        push_load(511, 511);
        word_q.push_back('{OP_LOAD, 9'd1, 9'd1, 16'd32768, 16'd32768, 16'd32768, 16'd32768});
        gen_written[STORE_W + 1] = 1;
        void'(push_render(0, 0));
        void'(push_render(511, 0));
        void'(push_render(0, 511));
        void'(push_render(511, 511));
        void'(push_render(1, 1));

        run_phase(4, 3, 128, -64, 0, EDGE_CLAMP, 255, RENDERS);
        run_phase(8, 8, -262144, 262143, 0, EDGE_TILE, 32768, RENDERS);
        run_phase(0, 1023, 300, 77, 1, 3, 0, RENDERS);
        run_phase(5, 6, 1000, -1000, 0, EDGE_ZERO, 65535, RENDERS);
        wait_idle();
        src_idle = 77;
        snk_idle = 23;
        run_phase(1, 1, 129, -129, 0, EDGE_TILE, 255, RENDERS);
        run_phase(512, 512, -300, 450, 0, EDGE_CLAMP, 0, RENDERS);
        run_phase(7, 2, $urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048,
                  1, EDGE_TILE, 255, RENDERS);
        run_phase(3, 5, 127, 128, 1, EDGE_CLAMP, 32768, RENDERS);
        wait_idle();
        src_idle = 0;
        snk_idle = 0;
        run_phase(6, 4, $urandom_range(0, 1023) - 512, $urandom_range(0, 1023) - 512,
                  0, 3, 1, RENDERS);
        run_phase(512, 512, 262143, -262144, 0, EDGE_ZERO, 255, RENDERS);
        run_phase(2, 7, $urandom_range(0, 511) - 256, 37, 1, EDGE_ZERO, 1000, RENDERS);
        run_phase(8, 8, $urandom_range(0, 8191) - 4096, $urandom_range(0, 8191) - 4096,
                  0, EDGE_TILE, 32768, RENDERS);
        wait_idle();

        if (err_cnt == 0 && pixel_q.size() == 0) begin
            $display("** subpixel_shift_bilinear: PASSED **");
        end else begin
            $display("** subpixel_shift_bilinear: FAILED **");
        end
        $finish;
    end

endmodule
